/* src/shortest_path_engine_defines.svh */
// ----------------------------------------------------------------------------
// shortest_path_engine_defines
// Assertion macros shared by the shortest path engine checkers.
// ----------------------------------------------------------------------------
`ifndef SHORTEST_PATH_ENGINE_DEFINES_SVH
`define SHORTEST_PATH_ENGINE_DEFINES_SVH

// checked outside reset only
`define SPE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define SPE_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/spe_pkg.sv */
// ----------------------------------------------------------------------------
// spe_pkg
// Shared widths and codes of the shortest path engine.
// ----------------------------------------------------------------------------
package spe_pkg;

  localparam int NODE_W   = 6;
  localparam int CFG_W    = 7;
  localparam int KIND_W   = 2;
  localparam int STAT_W   = 3;
  localparam int WIN_W    = 24;
  localparam int DOUT_W   = 32;
  localparam logic [CFG_W-1:0] NCOUNT_RST = 7'd64;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD = 2'd0,
    KIND_CHG = 2'd1,
    KIND_GET = 2'd2,
    KIND_QRY = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_NOPATH = 3'd1,
    ST_FULL   = 3'd2,
    ST_NOEDGE = 3'd3,
    ST_BAD    = 3'd4
  } status_t;

endpackage

/* src/spe_cmd_if.sv */
// ----------------------------------------------------------------------------
// spe_cmd_if
// Command channel: one beat is one graph command.
// ----------------------------------------------------------------------------
interface spe_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [spe_pkg::KIND_W-1:0]   kind;
  logic [spe_pkg::NODE_W-1:0]   node_a;
  logic [spe_pkg::NODE_W-1:0]   node_b;
  logic [spe_pkg::WIN_W-1:0]    weight;

  modport source (output valid, kind, node_a, node_b, weight, input ready);
  modport sink   (input valid, kind, node_a, node_b, weight, output ready);
endinterface

/* src/spe_res_if.sv */
// ----------------------------------------------------------------------------
// spe_res_if
// Result channel: one beat per status or path node.
// ----------------------------------------------------------------------------
interface spe_res_if;
  logic                         valid;
  logic                         ready;
  logic [spe_pkg::STAT_W-1:0]   status;
  logic [spe_pkg::NODE_W-1:0]   path_node;
  logic [spe_pkg::DOUT_W-1:0]   distance;
  logic                         last;

  modport source (output valid, status, path_node, distance, last, input ready);
  modport sink   (input valid, status, path_node, distance, last, output ready);
endinterface

/* src/spe_cfg_if.sv */
// ----------------------------------------------------------------------------
// spe_cfg_if
// Configuration write channel for the node count register.
// ----------------------------------------------------------------------------
interface spe_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [spe_pkg::CFG_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* src/spe_ram.sv */
// ----------------------------------------------------------------------------
// spe_ram
// Simple dual-port synchronous ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module spe_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/shortest_path_engine.sv */
// ----------------------------------------------------------------------------
// shortest_path_engine
// Undirected weighted graph store with a shortest path query. Commands are
// taken one at a time. Add writes the edge into both adjacency lists; change
// and get scan the adjacency ram serially. A query first initialises the
// distance of each of the n nodes, then for every settled node runs a
// minimum scan through the node ram and relaxes each listed edge, then
// traces the path node by node and emits one result beat per path node,
// n being the node count in use. Degree counts are cleared at reset by
// valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module shortest_path_engine #(
  parameter int NODES       = 64,
  parameter int MAX_DEGREE  = 8,
  parameter int WEIGHT_BITS = 24,
  parameter int DIST_BITS   = 32
) (
  input  logic      clk,
  input  logic      rst,
  spe_cmd_if.sink   cmd,
  spe_res_if.source res,
  spe_cfg_if.sink   cfg
);

  localparam int NW     = spe_pkg::NODE_W;
  localparam int CW     = spe_pkg::CFG_W;
  localparam int OW     = spe_pkg::DOUT_W;
  localparam int NA     = $clog2(NODES);
  localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
  localparam int ADJ_D  = NODES * MAX_DEGREE;
  localparam int ADJ_AW = $clog2(ADJ_D);
  localparam int ADJ_W  = NW + WEIGHT_BITS;
  localparam int NOD_W  = 1 + NW + DIST_BITS;
  localparam int SW     = (DIST_BITS > WEIGHT_BITS ? DIST_BITS : WEIGHT_BITS) + 1;
  localparam int DX     = DIST_BITS > OW ? DIST_BITS : OW;
  localparam logic [DIST_BITS-1:0] ONES = {DIST_BITS{1'b1}};

  typedef enum logic [21:0] {
    S_IDLE = 22'd1,      S_RESP = 22'd2,      S_DEGA = 22'd4,
    S_DEGB = 22'd8,      S_DEGC = 22'd16,     S_ADDA = 22'd32,
    S_ADDB = 22'd64,     S_FRD  = 22'd128,    S_FCK  = 22'd256,
    S_CHGA = 22'd512,    S_CHGB = 22'd1024,   S_INIT = 22'd2048,
    S_SCAN = 22'd4096,   S_SET  = 22'd8192,   S_RDEG = 22'd16384,
    S_RADJ = 22'd32768,  S_RNOD = 22'd65536,  S_RCMP = 22'd131072,
    S_PRD  = 22'd262144, S_PCK  = 22'd524288, S_EMIT = 22'd1048576,
    S_EOUT = 22'd2097152
  } state_t;

  state_t state;

  // ram ports
  logic              adj_we;
  logic [ADJ_AW-1:0] adj_waddr, adj_raddr;
  logic [ADJ_W-1:0]  adj_wdata, adj_rdata;
  logic              deg_we;
  logic [NA-1:0]     deg_waddr, deg_raddr;
  logic [DEG_W-1:0]  deg_wdata, deg_rdata;
  logic              nod_we;
  logic [NA-1:0]     nod_waddr, nod_raddr;
  logic [NOD_W-1:0]  nod_wdata, nod_rdata;
  logic              pth_we;
  logic [NA-1:0]     pth_waddr, pth_raddr;
  logic [NW-1:0]     pth_wdata, pth_rdata;

  // control and payload registers
  logic [CW-1:0]          node_count;
  logic [NODES-1:0]       deg_vld;
  logic [NA-1:0]          deg_rq;
  spe_pkg::kind_t         kind_q;
  logic [NW-1:0]          a_q, b_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic [DEG_W-1:0]       deg_a, deg_b, idx, ia, ib;
  logic                   second;
  logic [CW-1:0]          scan_i, plen, emit_k;
  logic                   chk_v, found;
  logic [NW-1:0]          chk_i, best, best_pred, cur, to_q;
  logic [DIST_BITS-1:0]   bd, nd_q, tgt_d;
  logic [spe_pkg::STAT_W-1:0] p_status;
  logic [OW-1:0]          p_dist;
  logic                   out_valid;
  logic [spe_pkg::STAT_W-1:0] r_status;
  logic [NW-1:0]          r_node;
  logic [OW-1:0]          r_dist;
  logic                   r_last;

  // derived values
  logic [CW-1:0]          eff_n;
  logic [DEG_W-1:0]       deg_eff, fdeg, pos_b;
  logic [NW-1:0]          f_from, f_to, adj_to, nod_pred;
  logic [WEIGHT_BITS-1:0] adj_w;
  logic                   nod_set, out_free, out_load, full, bad_in;
  logic [DIST_BITS-1:0]   nod_dist, nd;
  logic [SW-1:0]          sum;
  logic [DX-1:0]          tgt_x, ones_x;
  logic [OW-1:0]          w_ext;
  logic [CW-1:0]          eidx;
  logic [DEG_W:0]         need_a;

  function automatic logic [ADJ_AW-1:0] adj_addr(input logic [NW-1:0] node,
                                                  input logic [DEG_W-1:0] slot);
    return ADJ_AW'(node) * ADJ_AW'(MAX_DEGREE) + ADJ_AW'(slot);
  endfunction

  assign eff_n    = node_count > CW'(NODES) ? CW'(NODES) : node_count;
  assign deg_eff  = deg_vld[deg_rq] ? deg_rdata : '0;
  assign fdeg     = second ? deg_b : deg_a;
  assign f_from   = second ? b_q : a_q;
  assign f_to     = second ? a_q : b_q;
  assign adj_to   = adj_rdata[ADJ_W-1 -: NW];
  assign adj_w    = adj_rdata[WEIGHT_BITS-1:0];
  assign nod_set  = nod_rdata[NOD_W-1];
  assign nod_pred = nod_rdata[DIST_BITS +: NW];
  assign nod_dist = nod_rdata[DIST_BITS-1:0];
  assign sum      = SW'(bd) + SW'(adj_w);
  assign nd       = sum > SW'(ONES) ? ONES : sum[DIST_BITS-1:0];
  assign tgt_x    = DX'(tgt_d);
  assign ones_x   = DX'(ONES);
  assign w_ext    = {{(OW - spe_pkg::WIN_W){1'b0}}, cmd.weight};
  assign eidx     = plen - CW'(1) - emit_k;
  assign out_free = !out_valid || res.ready;
  assign out_load = out_free && (state == S_RESP || state == S_EOUT);
  assign pos_b    = (a_q == b_q) ? deg_a + DEG_W'(1) : deg_b;
  assign need_a   = (a_q == b_q) ? (DEG_W+1)'(2) : (DEG_W+1)'(1);
  assign full     = ({1'b0, deg_a} + need_a > (DEG_W+1)'(MAX_DEGREE)) ||
                    ({1'b0, deg_eff} + (DEG_W+1)'(1) > (DEG_W+1)'(MAX_DEGREE));
  assign bad_in   = ({1'b0, cmd.node_a} >= eff_n) || ({1'b0, cmd.node_b} >= eff_n);

  assign cmd.ready     = (state == S_IDLE);
  assign cfg.ready     = 1'b1;
  assign res.valid     = out_valid;
  assign res.status    = r_status;
  assign res.path_node = r_node;
  assign res.distance  = r_dist;
  assign res.last      = r_last;

  // ram address and write control
  always_comb begin
    adj_we = 1'b0; adj_waddr = '0; adj_wdata = '0; adj_raddr = '0;
    deg_we = 1'b0; deg_waddr = '0; deg_wdata = '0; deg_raddr = '0;
    nod_we = 1'b0; nod_waddr = '0; nod_wdata = '0; nod_raddr = '0;
    pth_we = 1'b0; pth_waddr = '0; pth_wdata = '0; pth_raddr = '0;
    case (state)
      S_DEGA: deg_raddr = a_q[NA-1:0];
      S_DEGB: deg_raddr = b_q[NA-1:0];
      S_ADDA: begin
        adj_we    = 1'b1;
        adj_waddr = adj_addr(a_q, deg_a);
        adj_wdata = {b_q, w_q};
        deg_we    = 1'b1;
        deg_waddr = a_q[NA-1:0];
        deg_wdata = deg_a + DEG_W'(1);
      end
      S_ADDB: begin
        adj_we    = 1'b1;
        adj_waddr = adj_addr(b_q, pos_b);
        adj_wdata = {a_q, w_q};
        deg_we    = 1'b1;
        deg_waddr = b_q[NA-1:0];
        deg_wdata = pos_b + DEG_W'(1);
      end
      S_FRD: adj_raddr = adj_addr(f_from, idx);
      S_CHGA: begin
        adj_we    = 1'b1;
        adj_waddr = adj_addr(a_q, ia);
        adj_wdata = {b_q, w_q};
      end
      S_CHGB: begin
        adj_we    = 1'b1;
        adj_waddr = adj_addr(b_q, ib);
        adj_wdata = {a_q, w_q};
      end
      S_INIT: begin
        nod_we    = 1'b1;
        nod_waddr = scan_i[NA-1:0];
        nod_wdata = {1'b0, {NW{1'b0}}, (scan_i == {1'b0, a_q}) ? '0 : ONES};
      end
      S_SCAN: nod_raddr = scan_i[NA-1:0];
      S_SET: begin
        nod_we    = 1'b1;
        nod_waddr = best[NA-1:0];
        nod_wdata = {1'b1, best_pred, bd};
        deg_raddr = best[NA-1:0];
      end
      S_RADJ: adj_raddr = adj_addr(best, idx);
      S_RNOD: nod_raddr = adj_to[NA-1:0];
      S_RCMP: begin
        if (nd_q < nod_dist) begin
          nod_we    = 1'b1;
          nod_waddr = to_q[NA-1:0];
          nod_wdata = {nod_set, best, nd_q};
        end
      end
      S_PRD: begin
        pth_we    = 1'b1;
        pth_waddr = plen[NA-1:0];
        pth_wdata = cur;
        nod_raddr = cur[NA-1:0];
      end
      S_EMIT, S_EOUT: pth_raddr = eidx[NA-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      node_count <= spe_pkg::NCOUNT_RST;
      deg_vld    <= '0;
    end else begin
      deg_rq <= deg_raddr;
      if (cfg.valid) begin
        node_count <= cfg.data;
      end
      if (deg_we) begin
        deg_vld[deg_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            kind_q <= spe_pkg::kind_t'(cmd.kind);
            a_q    <= cmd.node_a;
            b_q    <= cmd.node_b;
            w_q    <= w_ext[WEIGHT_BITS-1:0];
            if (bad_in) begin
              p_status <= spe_pkg::ST_BAD;
              p_dist   <= '0;
              state    <= S_RESP;
            end else if (spe_pkg::kind_t'(cmd.kind) == spe_pkg::KIND_QRY) begin
              scan_i <= '0;
              state  <= S_INIT;
            end else begin
              state <= S_DEGA;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            r_status  <= p_status;
            r_node    <= '0;
            r_dist    <= p_dist;
            r_last    <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_DEGA: state <= S_DEGB;
        S_DEGB: begin
          deg_a <= deg_eff;
          state <= S_DEGC;
        end
        S_DEGC: begin
          deg_b  <= deg_eff;
          idx    <= '0;
          second <= 1'b0;
          if (kind_q == spe_pkg::KIND_ADD) begin
            if (full) begin
              p_status <= spe_pkg::ST_FULL;
              p_dist   <= '0;
              state    <= S_RESP;
            end else begin
              state <= S_ADDA;
            end
          end else begin
            state <= S_FRD;
          end
        end
        S_ADDA: state <= S_ADDB;
        S_ADDB: begin
          p_status <= spe_pkg::ST_OK;
          p_dist   <= '0;
          state    <= S_RESP;
        end
        S_FRD: begin
          if (idx >= fdeg) begin
            p_status <= spe_pkg::ST_NOEDGE;
            p_dist   <= (kind_q == spe_pkg::KIND_GET) ? ones_x[OW-1:0] : '0;
            state    <= S_RESP;
          end else begin
            state <= S_FCK;
          end
        end
        S_FCK: begin
          if (adj_to == f_to) begin
            if (kind_q == spe_pkg::KIND_GET) begin
              p_status <= spe_pkg::ST_OK;
              p_dist   <= OW'(adj_w);
              state    <= S_RESP;
            end else if (!second) begin
              ia     <= idx;
              second <= 1'b1;
              idx    <= '0;
              state  <= S_FRD;
            end else begin
              ib    <= idx;
              state <= S_CHGA;
            end
          end else begin
            idx   <= idx + DEG_W'(1);
            state <= S_FRD;
          end
        end
        S_CHGA: state <= S_CHGB;
        S_CHGB: begin
          p_status <= spe_pkg::ST_OK;
          p_dist   <= '0;
          state    <= S_RESP;
        end
        S_INIT: begin
          if (scan_i == eff_n - CW'(1)) begin
            scan_i <= '0;
            chk_v  <= 1'b0;
            found  <= 1'b0;
            bd     <= ONES;
            state  <= S_SCAN;
          end else begin
            scan_i <= scan_i + CW'(1);
          end
        end
        S_SCAN: begin
          if (scan_i < eff_n) begin
            chk_v  <= 1'b1;
            chk_i  <= scan_i[NW-1:0];
            scan_i <= scan_i + CW'(1);
          end else begin
            chk_v <= 1'b0;
          end
          if (chk_v && !nod_set && nod_dist < bd) begin
            bd        <= nod_dist;
            best      <= chk_i;
            best_pred <= nod_pred;
            found     <= 1'b1;
          end
          if (scan_i >= eff_n && !chk_v) begin
            if (!found) begin
              p_status <= spe_pkg::ST_NOPATH;
              p_dist   <= ones_x[OW-1:0];
              state    <= S_RESP;
            end else begin
              state <= S_SET;
            end
          end
        end
        S_SET: begin
          if (best == b_q) begin
            tgt_d <= bd;
            cur   <= b_q;
            plen  <= '0;
            state <= S_PRD;
          end else begin
            state <= S_RDEG;
          end
        end
        S_RDEG: begin
          deg_a <= deg_eff;
          idx   <= '0;
          state <= S_RADJ;
        end
        S_RADJ: begin
          if (idx >= deg_a) begin
            scan_i <= '0;
            chk_v  <= 1'b0;
            found  <= 1'b0;
            bd     <= ONES;
            state  <= S_SCAN;
          end else begin
            state <= S_RNOD;
          end
        end
        S_RNOD: begin
          to_q <= adj_to;
          nd_q <= nd;
          if ({1'b0, adj_to} >= eff_n) begin
            idx   <= idx + DEG_W'(1);
            state <= S_RADJ;
          end else begin
            state <= S_RCMP;
          end
        end
        S_RCMP: begin
          idx   <= idx + DEG_W'(1);
          state <= S_RADJ;
        end
        S_PRD: begin
          plen <= plen + CW'(1);
          if (cur == a_q || plen + CW'(1) == CW'(NODES)) begin
            emit_k <= '0;
            state  <= S_EMIT;
          end else begin
            state <= S_PCK;
          end
        end
        S_PCK: begin
          cur   <= nod_pred;
          state <= S_PRD;
        end
        S_EMIT: state <= S_EOUT;
        S_EOUT: begin
          if (out_free) begin
            r_status  <= spe_pkg::ST_OK;
            r_node    <= pth_rdata;
            r_dist    <= tgt_x[OW-1:0];
            r_last    <= (emit_k == plen - CW'(1));
            if (emit_k == plen - CW'(1)) begin
              state <= S_IDLE;
            end else begin
              emit_k <= emit_k + CW'(1);
              state  <= S_EMIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  spe_ram #(.DEPTH(ADJ_D), .WIDTH(ADJ_W)) u_adj_ram (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );

  spe_ram #(.DEPTH(NODES), .WIDTH(DEG_W)) u_deg_ram (
    .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .raddr(deg_raddr), .rdata(deg_rdata)
  );

  spe_ram #(.DEPTH(NODES), .WIDTH(NOD_W)) u_nod_ram (
    .clk(clk), .we(nod_we), .waddr(nod_waddr), .wdata(nod_wdata),
    .raddr(nod_raddr), .rdata(nod_rdata)
  );

  spe_ram #(.DEPTH(NODES), .WIDTH(NW)) u_pth_ram (
    .clk(clk), .we(pth_we), .waddr(pth_waddr), .wdata(pth_wdata),
    .raddr(pth_raddr), .rdata(pth_rdata)
  );

endmodule

/* src/spe_chk.sv */
// ----------------------------------------------------------------------------
// spe_chk
// Port-level checks of the shortest path engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "shortest_path_engine_defines.svh"

module spe_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [spe_pkg::STAT_W-1:0]   res_status,
  input logic                         res_last
);

  // a stalled result beat stays offered
  `SPE_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid, "result beat dropped")

  // one command in flight at a time
  `SPE_ASSERT(a_one_cmd, cmd_valid && cmd_ready |=> !cmd_ready, "command taken while busy")

  // only path beats run on without last
  `SPE_ASSERT(a_mid_ok, res_valid && !res_last |-> res_status == spe_pkg::ST_OK, "bad mid status")

  // nothing offered right after reset
  `SPE_ASSERT_RST(a_rst_quiet, rst |=> !res_valid, "result valid after reset")

endmodule

bind shortest_path_engine spe_chk u_spe_chk (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_status (res.status),
  .res_last   (res.last)
);
